// ----- design/c2p_pkg.sv -----
package c2p_pkg;

  // low four bits of the column counter all ones marks the 16th pixel of a group
  localparam logic [3:0] GroupMask = 4'hF;

  localparam int PixelW    = 8;
  localparam int WordW     = 16;
  localparam int PlaneNumW = 3;
  localparam int CountW    = 16;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgPlaneMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRowWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRowCount  = 2'd2;

  localparam logic [1:0]        PlaneModeRst = 2'd3;
  localparam logic [CountW-1:0] RowWidthRst  = 16'd320;
  localparam logic [CountW-1:0] RowCountRst  = 16'd200;

  // per-group control that travels with the plane words
  typedef struct packed {
    logic [PlaneNumW-1:0] last_plane;
    logic                 img_end;
  } group_info_t;

endpackage

// ----- design/c2p_front.sv -----
module c2p_front #(
  parameter int MaxPlanes = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [1:0]                            plane_mode_i,
  input  logic [c2p_pkg::CountW-1:0]            row_width_i,
  input  logic [c2p_pkg::CountW-1:0]            row_count_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [c2p_pkg::PixelW-1:0]            pixel_index_i,
  input  logic                                  q_full_i,
  output logic                                  push_o,
  output logic [MaxPlanes-1:0][c2p_pkg::WordW-1:0] push_words_o,
  output c2p_pkg::group_info_t                  push_info_o
);
  import c2p_pkg::*;

  logic [MaxPlanes-1:0][WordW-1:0] acc_q, acc_d, shifted;
  logic [CountW-1:0] col_q, col_d, row_q, row_d;
  logic accept, group_done, row_end, img_end;
  logic [PlaneNumW-1:0] last_raw, last_plane;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    for (int k = 0; k < MaxPlanes; k++) begin
      shifted[k] = {acc_q[k][WordW-2:0], pixel_index_i[k]};
    end
  end

  assign group_done = (col_q[3:0] & GroupMask) == GroupMask;
  assign row_end    = ({1'b0, col_q} + 17'd1) >= {1'b0, row_width_i};
  assign img_end    = row_end && (({1'b0, row_q} + 17'd1) >= {1'b0, row_count_i});

  // active planes saturate at what is built
  always_comb begin
    case (plane_mode_i)
      2'd0:    last_raw = 3'd0;
      2'd1:    last_raw = 3'd1;
      2'd2:    last_raw = 3'd3;
      default: last_raw = 3'd7;
    endcase
    if (last_raw > PlaneNumW'(MaxPlanes - 1)) begin
      last_plane = PlaneNumW'(MaxPlanes - 1);
    end else begin
      last_plane = last_raw;
    end
  end

  always_comb begin
    acc_d = acc_q;
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      acc_d = (group_done || row_end) ? '0 : shifted;
      if (row_end) begin
        col_d = '0;
        row_d = img_end ? '0 : row_q + 16'd1;
      end else begin
        col_d = col_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      col_q <= '0;
      row_q <= '0;
    end else begin
      acc_q <= acc_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign push_o                 = accept && group_done;
  assign push_words_o           = shifted;
  assign push_info_o.last_plane = last_plane;
  assign push_info_o.img_end    = img_end;

endmodule

// ----- design/c2p_queue.sv -----
module c2p_queue #(
  parameter int MaxPlanes = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  input  logic [MaxPlanes-1:0][c2p_pkg::WordW-1:0] push_words_i,
  input  c2p_pkg::group_info_t                  push_info_i,
  output logic                                  full_o,
  output logic                                  head_valid_o,
  output logic [MaxPlanes-1:0][c2p_pkg::WordW-1:0] head_words_o,
  output c2p_pkg::group_info_t                  head_info_o,
  input  logic                                  pop_i
);
  import c2p_pkg::*;

  // two groups deep
  logic [MaxPlanes-1:0][WordW-1:0] words_q [2];
  group_info_t                     info_q  [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o       = cnt_q == 2'd2;
  assign head_valid_o = cnt_q != 2'd0;
  assign head_words_o = words_q[rd_ptr_q];
  assign head_info_o  = info_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      words_q[wr_ptr_q] <= push_words_i;
      info_q[wr_ptr_q]  <= push_info_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- design/c2p_back.sv -----
module c2p_back #(
  parameter int MaxPlanes = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  head_valid_i,
  input  logic [MaxPlanes-1:0][c2p_pkg::WordW-1:0] head_words_i,
  input  c2p_pkg::group_info_t                  head_info_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [c2p_pkg::WordW-1:0]             plane_word_o,
  output logic [c2p_pkg::PlaneNumW-1:0]         plane_number_o,
  output logic                                  group_last_o,
  output logic                                  image_last_o
);
  import c2p_pkg::*;

  localparam int IdxW = (MaxPlanes > 1) ? $clog2(MaxPlanes) : 1;

  logic [IdxW-1:0]      idx_q, idx_d;
  logic [PlaneNumW-1:0] idx_ext;
  logic                 load, at_last, valid_q, valid_d;
  logic [WordW-1:0]     word_q;
  logic [PlaneNumW-1:0] num_q;
  logic                 glast_q, ilast_q;

  assign idx_ext = PlaneNumW'(idx_q);
  assign at_last = idx_ext == head_info_i.last_plane;
  assign load    = head_valid_i && (!valid_q || !out_stall_i);
  assign pop_o   = load && at_last;

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = at_last ? '0 : idx_q + IdxW'(1);
    end
    if (load) begin
      valid_d = 1'b1;
    end else begin
      valid_d = valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q  <= head_words_i[idx_q];
      num_q   <= idx_ext;
      glast_q <= at_last;
      ilast_q <= at_last && head_info_i.img_end;
    end
  end

  assign out_valid_o    = valid_q;
  assign plane_word_o   = word_q;
  assign plane_number_o = num_q;
  assign group_last_o   = glast_q;
  assign image_last_o   = ilast_q;

endmodule

// ----- design/chunky_to_bitplane_converter.sv -----
// a pixel that completes a group is written into the group queue, and its plane 0 word
// then leaves through the output register; throughput: one pixel per cycle while the
// queue is not full; words leave one per cycle while out_stall_i is low, 1 to
// MaxPlanes words per 16-pixel group, set by plane_mode; reset: counters, accumulators
// and group queue clear; plane_mode 3, row_width 320, row_count 200
module chunky_to_bitplane_converter #(
  parameter int MaxPlanes = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [c2p_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [c2p_pkg::CountW-1:0]      cfg_data_i,
  // pixel input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [c2p_pkg::PixelW-1:0]      pixel_index_i,
  // plane word output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [c2p_pkg::WordW-1:0]       plane_word_o,
  output logic [c2p_pkg::PlaneNumW-1:0]   plane_number_o,
  output logic                            group_last_o,
  output logic                            image_last_o
);
  import c2p_pkg::*;

  // configuration registers
  logic [1:0]        plane_mode_q;
  logic [CountW-1:0] row_width_q, row_count_q;

  // front to queue
  logic                            push, q_full;
  logic [MaxPlanes-1:0][WordW-1:0] push_words;
  group_info_t                     push_info;

  // queue to back
  logic                            head_valid, pop;
  logic [MaxPlanes-1:0][WordW-1:0] head_words;
  group_info_t                     head_info;

  // unknown register indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_mode_q <= PlaneModeRst;
      row_width_q  <= RowWidthRst;
      row_count_q  <= RowCountRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPlaneMode: plane_mode_q <= cfg_data_i[1:0];
        CfgRowWidth:  row_width_q  <= cfg_data_i;
        CfgRowCount:  row_count_q  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // front: shifts each pixel into the plane accumulators and tracks row/column
  c2p_front #(.MaxPlanes(MaxPlanes)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .plane_mode_i  (plane_mode_q),
    .row_width_i   (row_width_q),
    .row_count_i   (row_count_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_index_i (pixel_index_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_words_o  (push_words),
    .push_info_o   (push_info)
  );

  // two-group queue decouples pixel intake from word emission
  c2p_queue #(.MaxPlanes(MaxPlanes)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_words_i (push_words),
    .push_info_i  (push_info),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_words_o (head_words),
    .head_info_o  (head_info),
    .pop_i        (pop)
  );

  // back: walks the active planes of the head group, one word per item
  c2p_back #(.MaxPlanes(MaxPlanes)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_words_i   (head_words),
    .head_info_i    (head_info),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .plane_word_o   (plane_word_o),
    .plane_number_o (plane_number_o),
    .group_last_o   (group_last_o),
    .image_last_o   (image_last_o)
  );

endmodule

// ----- sim/tb_chunky_to_bitplane_converter.sv -----
module tb_chunky_to_bitplane_converter;
  import c2p_pkg::*;

  localparam int MaxPlanes = 8;
  // index with no register behind it, writes to it must be dropped
  localparam logic [CfgIdxW-1:0] CfgNoReg = 2'd3;
  localparam int GapPct      = 30;
  // words pass the group queue and the output register after the group's last pixel, keep some margin
  localparam int DrainCycles = 6;
  localparam int PhaseItems  = 33;
  // all-zero, all-one, alternating and single-bit pixels
  localparam logic [6*PixelW-1:0] CornerPix = 48'h00FF55AA0180;

  // one plane word as the block should emit it
  typedef struct packed {
    logic [WordW-1:0]     word;
    logic [PlaneNumW-1:0] plane;
    logic                 group_last;
    logic                 image_last;
  } plane_word_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [CountW-1:0]    cfg_data_i    = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [PixelW-1:0]    pixel_index_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [WordW-1:0]     plane_word_o;
  logic [PlaneNumW-1:0] plane_number_o;
  logic                 group_last_o;
  logic                 image_last_o;

  // stretch with neither side idling
  bit no_idle  = 1'b0;
  int n_errors = 0;

  // expected plane words, oldest first
  plane_word_t words_due[$];
  plane_word_t got_due;

  // shadow of the block's registers and state
  logic [1:0]        plane_mode_q = PlaneModeRst;
  logic [CountW-1:0] row_width_q  = RowWidthRst;
  logic [CountW-1:0] row_count_q  = RowCountRst;
  logic [WordW-1:0]  acc_q [MaxPlanes] = '{default: '0};
  logic [CountW-1:0] col_q = '0;
  logic [CountW-1:0] row_q = '0;

  chunky_to_bitplane_converter #(
    .MaxPlanes(MaxPlanes)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_index_i (pixel_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .plane_word_o  (plane_word_o),
    .plane_number_o(plane_number_o),
    .group_last_o  (group_last_o),
    .image_last_o  (image_last_o)
  );

  always #4 clk_i = ~clk_i;

  // shift one pixel into the planes, queue the words of a completed group
  function automatic void convert_pixel(input logic [PixelW-1:0] pix);
    int  planes;
    bit  row_end;
    bit  img_end;
    plane_word_t w;
    planes  = 1 << plane_mode_q;
    if (planes > MaxPlanes) planes = MaxPlanes;
    row_end = (int'(col_q) + 1) >= int'(row_width_q);
    img_end = row_end && ((int'(row_q) + 1) >= int'(row_count_q));
    for (int k = 0; k < MaxPlanes; k++) begin
      // index bits beyond 8 planes would shift in zero
      acc_q[k] = {acc_q[k][WordW-2:0], (k < PixelW) ? pix[k] : 1'b0};
    end
    // 16th pixel of a group: one word per active plane, plane 0 first
    if (col_q[3:0] == GroupMask) begin
      for (int k = 0; k < planes; k++) begin
        w.word       = acc_q[k];
        w.plane      = PlaneNumW'(k);
        w.group_last = (k == planes - 1);
        w.image_last = (k == planes - 1) && img_end;
        words_due.push_back(w);
      end
      acc_q = '{default: '0};
    end
    // a row end drops any partial group
    if (row_end) begin
      col_q = '0;
      acc_q = '{default: '0};
      row_q = img_end ? '0 : row_q + 1'b1;
    end else begin
      col_q = col_q + 1'b1;
    end
  endfunction

  // register writes and accepted pixels feed the shadow model
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPlaneMode: plane_mode_q = cfg_data_i[1:0];
          CfgRowWidth:  row_width_q  = cfg_data_i;
          CfgRowCount:  row_count_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) convert_pixel(pixel_index_i);
    end
  end

  function automatic void check_field(input string what, input logic [WordW-1:0] want,
                                      input logic [WordW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      n_errors++;
    end
  endfunction

  // compare each accepted word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (words_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %0h plane %0d",
                 $time, plane_word_o, plane_number_o);
        n_errors++;
      end else begin
        got_due = words_due.pop_front();
        check_field("plane_word", got_due.word, plane_word_o);
        check_field("plane_number", WordW'(got_due.plane), WordW'(plane_number_o));
        check_field("group_last", WordW'(got_due.group_last), WordW'(group_last_o));
        check_field("image_last", WordW'(got_due.image_last), WordW'(image_last_o));
      end
    end
  end

  // random back-pressure on the word side
  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < GapPct);
  end

  // valid stays up across back-to-back items, it only drops in a gap
  task automatic send_pixel(input logic [PixelW-1:0] pix);
    while (!no_idle && $urandom_range(99) < GapPct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_index_i <= pix;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // hold the pixel side until every queued word is out and the pipe is empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CountW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // plane mode goes in with random upper bits, which the block must ignore
  task automatic configure(input logic [1:0] mode, input logic [CountW-1:0] width,
                           input logic [CountW-1:0] rows);
    logic [CountW-1:0] mode_data;
    mode_data      = CountW'($urandom);
    mode_data[1:0] = mode;
    write_reg(CfgPlaneMode, mode_data);
    write_reg(CfgRowWidth, width);
    write_reg(CfgRowCount, rows);
  endtask

  // reset settings: 8 planes, one full group of corner and random pixels
  task automatic test_reset_values();
    for (int i = 0; i < 16; i++) begin
      if (i < 6) send_pixel(CornerPix[(5-i)*PixelW +: PixelW]);
      else send_pixel(PixelW'($urandom_range(255)));
    end
    wait_idle();
  endtask

  // row width cut below the column counter ends the row on the next pixel,
  // then a single-plane group that also closes the image
  task automatic test_shrunk_row();
    write_reg(CfgRowWidth, 16'd16);
    write_reg(CfgRowCount, 16'd1);
    write_reg(CfgPlaneMode, 16'd0);
    send_pixel(8'hFF);
    for (int i = 0; i < 16; i++) send_pixel(PixelW'($urandom_range(255)));
    wait_idle();
  endtask

  // 18-pixel row: one two-plane group, the last two pixels are dropped
  task automatic test_partial_group();
    configure(2'd1, 16'd18, 16'd2);
    for (int i = 0; i < 18; i++) send_pixel(PixelW'($urandom_range(255)));
    wait_idle();
  endtask

  // zero and one pixel rows never complete a group, unmapped index is a no-op
  task automatic test_degenerate_rows();
    write_reg(CfgNoReg, CountW'($urandom));
    configure(2'd2, 16'd0, 16'd0);
    repeat (3) send_pixel(PixelW'($urandom_range(255)));
    wait_idle();
    write_reg(CfgRowWidth, 16'd1);
    repeat (2) send_pixel(PixelW'($urandom_range(255)));
    wait_idle();
  endtask

  // phases of random pixels under fixed extreme settings, then random ones;
  // counters carry over from phase to phase
  task automatic test_random_streams();
    logic [1:0]        mode;
    logic [CountW-1:0] width;
    logic [CountW-1:0] rows;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin mode = 2'd0; width = 16'd16;    rows = 16'd1;     end
        1: begin mode = 2'd3; width = 16'hFFFF;  rows = 16'hFFFF;  end
        2: begin mode = 2'd1; width = 16'd17;    rows = 16'd0;     end
        3: begin mode = 2'd2; width = 16'd48;    rows = 16'd3;     end
        default: begin
          mode = 2'($urandom_range(3));
          case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: width = CountW'(16 * $urandom_range(1, 3));
            6, 7:             width = CountW'($urandom_range(1, 70));
            8:                width = CountW'($urandom_range(0, 1));
            default:          width = 16'hFFFF;
          endcase
          rows = ($urandom_range(7) == 0) ? 16'hFFFF : CountW'($urandom_range(0, 4));
        end
      endcase
      configure(mode, width, rows);
      // first phase runs with no idling on either side
      no_idle = (p == 0);
      for (int i = 0; i < PhaseItems; i++) begin
        // let the word side run dry mid-stream now and then
        if (i == PhaseItems / 2 && (p == 1 || $urandom_range(1) == 1)) wait_idle();
        send_pixel(PixelW'($urandom_range(255)));
      end
      wait_idle();
      no_idle = 1'b0;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_shrunk_row();
    test_partial_group();
    test_degenerate_rows();
    test_random_streams();
    wait_idle();
    if (n_errors == 0) begin
      $display("tb_chunky_to_bitplane_converter: done, clean");
    end else begin
      $display("tb_chunky_to_bitplane_converter: done, errors");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("tb_chunky_to_bitplane_converter: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
design/c2p_pkg.sv
design/c2p_front.sv
design/c2p_queue.sv
design/c2p_back.sv
design/chunky_to_bitplane_converter.sv
sim/tb_chunky_to_bitplane_converter.sv
